// ----- design/pie_pkg.sv -----
// Shared constants, codes and the per-cell command struct for the
// positional insert/erase list. No dependencies.
package pie_pkg;

    localparam int CAPACITY = 32;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic               do_ins;
        logic               do_era;
        logic [CMP_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

// ----- design/pie_cell.sv -----
// One list cell: holds a single entry and shifts up, shifts down, loads or
// holds under the broadcast command. Depends on pie_pkg.
module pie_cell (
    input  logic                        i_clk,
    input  logic [pie_pkg::IDX_W-1:0]   i_index,
    input  pie_pkg::t_cell_cmd          i_cmd,
    input  logic [pie_pkg::DATA_W-1:0]  i_left,
    input  logic [pie_pkg::DATA_W-1:0]  i_right,
    output logic [pie_pkg::DATA_W-1:0]  o_data,
    output logic [pie_pkg::DATA_W-1:0]  o_tap
);
    import pie_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [CMP_W-1:0]  idx_x;

    assign idx_x = CMP_W'(i_index);

    always_comb begin
        n_data = r_data;
        if (i_cmd.do_ins) begin
            if (idx_x == i_cmd.pos) begin
                n_data = i_cmd.value;
            end else if (idx_x > i_cmd.pos) begin
                n_data = i_left;
            end
        end else if (i_cmd.do_era) begin
            // close the gap: take the entry above
            if (idx_x >= i_cmd.pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (idx_x == i_cmd.pos) ? r_data : '0;

endmodule

// ----- design/positional_insert_erase_list_core.sv -----
// Top level of the positional insert/erase list: request decode, entry count,
// the chain of pie_cell instances and the result register. Depends on pie_pkg.
//
// A beat accepted with start gives its result, marked by o_strobe, in the
// very next cycle, and busy never rises, so a new request may follow in every
// cycle. All entries shift in parallel in the cell chain. Results cannot be
// stalled; the receiver must take o_strobe beats as they come.
module positional_insert_erase_list_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pie_pkg::OP_W-1:0]    i_operation,
    input  logic [pie_pkg::POS_W-1:0]   i_position,
    input  logic signed [pie_pkg::DATA_W-1:0] i_value,
    output logic                        o_strobe,
    output logic [pie_pkg::ST_W-1:0]    o_status,
    output logic signed [pie_pkg::DATA_W-1:0] o_read_value,
    output logic [pie_pkg::CNT_W-1:0]   o_entry_count
);
    import pie_pkg::*;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CMP_W-1:0]     cnt_x;
    logic [CMP_W-1:0]     pos_x;
    logic [ST_W-1:0]      status;
    logic                 rd_ok;
    logic                 do_clr;
    t_cell_cmd            cmd;
    logic [DATA_W-1:0]    w_data [CAPACITY];
    logic [DATA_W-1:0]    w_tap  [CAPACITY];
    logic [DATA_W-1:0]    rd_val;

    logic                 r_strobe;
    logic [ST_W-1:0]      r_status;
    logic [DATA_W-1:0]    r_read_value;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);
    assign cnt_x  = CMP_W'(r_count);
    assign pos_x  = CMP_W'(i_position);

    always_comb begin
        status     = ST_OK;
        rd_ok      = 1'b0;
        do_clr     = 1'b0;
        cmd.do_ins = 1'b0;
        cmd.do_era = 1'b0;
        cmd.pos    = pos_x;
        cmd.value  = i_value;
        case (i_operation)
            OP_INSERT_AT: begin
                if (full) status = ST_FULL;
                else if (pos_x > cnt_x) status = ST_RANGE;
                else cmd.do_ins = accept;
            end
            OP_PUSH_FRONT: begin
                cmd.pos = '0;
                if (full) status = ST_FULL;
                else cmd.do_ins = accept;
            end
            OP_PUSH_BACK: begin
                cmd.pos = cnt_x;
                if (full) status = ST_FULL;
                else cmd.do_ins = accept;
            end
            OP_ERASE_AT: begin
                if (empty) status = ST_EMPTY;
                else if (pos_x >= cnt_x) status = ST_RANGE;
                else cmd.do_era = accept;
            end
            OP_POP_FRONT: begin
                cmd.pos = '0;
                if (empty) status = ST_EMPTY;
                else cmd.do_era = accept;
            end
            OP_POP_BACK: begin
                cmd.pos = cnt_x - CMP_W'(1);
                if (empty) status = ST_EMPTY;
                else cmd.do_era = accept;
            end
            OP_READ_AT: begin
                if (empty) status = ST_EMPTY;
                else if (pos_x >= cnt_x) status = ST_RANGE;
                else rd_ok = 1'b1;
            end
            OP_CLEAR: begin
                do_clr = 1'b1;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            pie_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(g)),
                .i_cmd   (cmd),
                .i_left  ((g == 0) ? w_data[0] : w_data[(g == 0) ? 0 : g - 1]),
                .i_right ((g == CAPACITY - 1) ? w_data[g]
                                              : w_data[(g == CAPACITY - 1) ? g : g + 1]),
                .o_data  (w_data[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero tap
    always_comb begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_val = rd_val | w_tap[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (do_clr) n_count = '0;
            else if (cmd.do_ins) n_count = r_count + CNT_W'(1);
            else if (cmd.do_era) n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= accept;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= status;
            r_read_value <= rd_ok ? rd_val : '0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start))
        else $error("result beat without a request");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |-> o_entry_count == '0)
        else $error("empty status on a non-empty list");

endmodule

// ----- verif/tb.sv -----
// Testbench for positional_insert_erase_list_core: directed and random list requests,
// each result checked against a shadow copy of the list kept in a small scoreboard class.
// Depends on pie_pkg and the core RTL only.
module tb;
    import pie_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
    } t_list_result;

    class t_list_scoreboard;
        logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
        int           fill;
        t_list_result expected_results [$];
        int           errors;
        int           requests;
        int           op_hits [8];
        int           status_hits [4];
        int           peak_fill;

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        // Shadow list update; returns what the core should answer.
        function t_list_result apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                             logic signed [DATA_W-1:0] val);
            t_list_result r;
            int at;
            r.status     = ST_OK;
            r.read_value = '0;
            at = int'(pos);
            case (op)
                OP_INSERT_AT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (op == OP_PUSH_FRONT) at = 0;
                    else if (op == OP_PUSH_BACK) at = fill;
                    // full wins over a bad position
                    if (fill >= CAPACITY) r.status = ST_FULL;
                    else if (at > fill) r.status = ST_RANGE;
                    else begin
                        for (int i = fill; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[at] = val;
                        fill++;
                    end
                end
                OP_ERASE_AT, OP_POP_FRONT, OP_POP_BACK: begin
                    if (op == OP_POP_FRONT) at = 0;
                    else if (op == OP_POP_BACK) at = fill - 1;
                    if (fill == 0) r.status = ST_EMPTY;
                    else if (at >= fill) r.status = ST_RANGE;
                    else begin
                        for (int i = at; i + 1 < fill; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        fill--;
                    end
                end
                OP_READ_AT: begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else if (at >= fill) r.status = ST_RANGE;
                    else r.read_value = shadow_entries[at];
                end
                default: fill = 0;
            endcase
            r.entry_count = CNT_W'(fill);
            return r;
        endfunction

        task note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                          logic signed [DATA_W-1:0] val);
            t_list_result r;
            r = apply_request(op, pos, val);
            requests++;
            op_hits[op]++;
            status_hits[r.status]++;
            if (fill > peak_fill) peak_fill = fill;
            expected_results.push_back(r);
        endtask

        task check_result(logic [ST_W-1:0] status, logic signed [DATA_W-1:0] rd,
                          logic [CNT_W-1:0] cnt);
            t_list_result want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: status %0d count %0d",
                                          status, cnt));
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (rd !== want.read_value)
                report_mismatch($sformatf("read_value %0d, want %0d", rd, want.read_value));
            if (cnt !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d", cnt, want.entry_count));
        endtask
    endclass

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     start         = 1'b0;
    logic [OP_W-1:0]          i_operation   = OP_CLEAR;
    logic [POS_W-1:0]         i_position    = '0;
    logic signed [DATA_W-1:0] i_value       = '0;
    logic                     busy;
    logic                     o_strobe;
    logic [ST_W-1:0]          o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic [CNT_W-1:0]         o_entry_count;

    t_list_scoreboard sb = new;
    int idle_cycles = 0;

    positional_insert_erase_list_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Note accepted beats before checking, so a same-cycle answer would still line up.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_request(i_operation, i_position, i_value);
        if (i_rst_n && o_strobe) sb.check_result(o_status, o_read_value, o_entry_count);
        if ((start && !busy) || o_strobe) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("[positional_insert_erase_list_core] ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int mode;
        int burst_len;
        int sent;
        int burst;
        int roll;
        int ins_cut;
        int era_cut;
        int rd_cut;
        int hi;
        bit quiet;
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list, bad positions, value extremes, append at count
        send_req(OP_CLEAR,      5'd0,  32'sd0, 0);
        send_req(OP_POP_FRONT,  5'd0,  32'sd0, 0);
        send_req(OP_POP_BACK,   5'd0,  32'sd0, 0);
        send_req(OP_ERASE_AT,   5'd0,  32'sd0, 0);
        send_req(OP_READ_AT,    5'd0,  32'sd0, 0);
        send_req(OP_INSERT_AT,  5'd1,  32'sd5, 0);
        send_req(OP_INSERT_AT,  5'd0,  32'h7fff_ffff, 0);
        send_req(OP_PUSH_FRONT, 5'd31, 32'h8000_0000, 0);
        send_req(OP_PUSH_BACK,  5'd17, 32'hffff_ffff, 0);
        send_req(OP_INSERT_AT,  5'd3,  32'sd0, 0);
        send_req(OP_INSERT_AT,  5'd1,  32'h5a5a_a5a5, 0);
        for (int i = 0; i < 5; i++) send_req(OP_READ_AT, 5'(i), 32'sd0, 0);
        send_req(OP_READ_AT,    5'd5,  32'sd0, 0);
        send_req(OP_READ_AT,    5'd31, 32'sd0, 0);
        send_req(OP_ERASE_AT,   5'd31, 32'sd0, 0);
        send_req(OP_INSERT_AT,  5'd31, 32'sd9, 0);
        send_req(OP_ERASE_AT,   5'd2,  32'sd0, 0);
        send_req(OP_POP_FRONT,  5'd0,  32'sd0, 0);
        send_req(OP_POP_BACK,   5'd0,  32'sd0, 0);
        send_req(OP_READ_AT,    5'd1,  32'sd0, 0);
        send_req(OP_CLEAR,      5'd0,  32'sd0, 0);
        send_req(OP_READ_AT,    5'd0,  32'sd0, 0);
        drain_results();

        // Bursts lean toward growing, shrinking or mixing so full and empty both recur.
        sent  = 0;
        burst = 0;
        while (sent < ITEM_TARGET) begin
            mode      = $urandom_range(0, 2);
            burst_len = $urandom_range(20, 90);
            quiet     = ($urandom_range(0, 2) == 0);
            case (mode)
                0:       begin ins_cut = 80; era_cut = 88; rd_cut = 99; end
                1:       begin ins_cut = 12; era_cut = 85; rd_cut = 99; end
                default: begin ins_cut = 40; era_cut = 75; rd_cut = 98; end
            endcase
            if (burst == 3 || $urandom_range(0, 4) == 0) drain_results();
            for (int k = 0; k < burst_len && sent < ITEM_TARGET; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_cut) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_INSERT_AT;
                        1:       op = OP_PUSH_FRONT;
                        default: op = OP_PUSH_BACK;
                    endcase
                    hi  = (sb.fill > 31) ? 31 : sb.fill;
                    pos = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, hi))
                                                      : POS_W'($urandom_range(0, 31));
                end else begin
                    if (roll < era_cut) begin
                        case ($urandom_range(0, 2))
                            0:       op = OP_ERASE_AT;
                            1:       op = OP_POP_FRONT;
                            default: op = OP_POP_BACK;
                        endcase
                    end else if (roll < rd_cut) op = OP_READ_AT;
                    else op = OP_CLEAR;
                    if (sb.fill > 0 && $urandom_range(0, 4) != 0)
                        pos = POS_W'($urandom_range(0, sb.fill - 1));
                    else
                        pos = POS_W'($urandom_range(0, 31));
                end
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       val = '0;
                        1:       val = '1;
                        2:       val = {1'b1, {(DATA_W-1){1'b0}}};
                        default: val = {1'b0, {(DATA_W-1){1'b1}}};
                    endcase
                end else begin
                    val = $urandom();
                end
                send_req(op, pos, val, quiet ? 0 : $urandom_range(0, 13));
                sent++;
            end
            burst++;
        end

        drain_results();
        repeat (4) @(negedge i_clk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch("results still outstanding at end of run");
        $display("%0d requests: insert %0d/%0d/%0d erase %0d/%0d/%0d read %0d clear %0d",
                 sb.requests, sb.op_hits[OP_INSERT_AT], sb.op_hits[OP_PUSH_FRONT],
                 sb.op_hits[OP_PUSH_BACK], sb.op_hits[OP_ERASE_AT], sb.op_hits[OP_POP_FRONT],
                 sb.op_hits[OP_POP_BACK], sb.op_hits[OP_READ_AT], sb.op_hits[OP_CLEAR]);
        $display("answers ok %0d full %0d empty %0d range %0d, peak fill %0d of %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
                 sb.status_hits[ST_RANGE], sb.peak_fill, CAPACITY);
        if (sb.errors == 0) begin
            $display("[positional_insert_erase_list_core] OK");
        end else begin
            $display("[positional_insert_erase_list_core] ERROR");
        end
        $finish;
    end

endmodule
